// ===== src/dbtsc_pkg.sv =====
`timescale 1ns / 1ps

package dbtsc_pkg;

  localparam int TEXTURE_SLOTS = 32;
  localparam int CACHE_QUADS   = 16;
  localparam int MAX_QUADS     = 1024;
  localparam int HANDLE_WIDTH  = 32;

  // output field widths
  localparam int KIND_W = 2;
  localparam int QC_W   = 11;
  localparam int OFF_W  = 10;
  localparam int TC_W   = 5;
  localparam int SLOT_OUT_W = 5;
  localparam int ID_W   = 32;

  // internal widths
  localparam int SLOT_W   = $clog2(TEXTURE_SLOTS);
  localparam int CACHE_W  = $clog2(CACHE_QUADS + 1);
  localparam int COMMIT_W = $clog2(MAX_QUADS + 1);
  localparam int SUM_W    = COMMIT_W + 1;

  localparam logic [KIND_W-1:0] EV_UPLOAD = 2'd0;
  localparam logic [KIND_W-1:0] EV_DRAW   = 2'd1;
  localparam logic [KIND_W-1:0] EV_SLOT   = 2'd2;

  localparam logic REQ_FLUSH = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_READ,
    S_SEARCH,
    S_END_UP,
    S_END_DRAW,
    S_STORE,
    S_EMIT_SLOT,
    S_CACHE_UP
  } state_t;

  // where to go once a batch has been ended
  typedef enum logic [1:0] {
    RET_IDLE,
    RET_LOOKUP,
    RET_STORE
  } ret_t;

endpackage

// ===== src/draw_batch_texture_slot_cache_core.sv =====
// A result shows the cycle after the state that makes it. A flush (or a draw that ends a full
// batch) passes through S_END_UP and S_END_DRAW; a white-slot draw through S_LOOKUP and S_EMIT_SLOT.
// A textured draw scans the slot table in S_READ and S_SEARCH (one memory read per cycle),
// stores a new handle in S_STORE, ends a batch in S_END_UP and S_END_DRAW, and uploads a full
// cache in S_CACHE_UP. The receiver cannot stall; results are strobes.
// Reset (rst, synchronous): next slot 1, quad counters 0; slot table not cleared.
`timescale 1ns / 1ps

module draw_batch_texture_slot_cache_core
  import dbtsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  req_type,
  input  logic                  has_texture,
  input  logic [ID_W-1:0]       texture_id,
  output logic                  event_valid,
  output logic [KIND_W-1:0]     event_kind,
  output logic [QC_W-1:0]       quad_count,
  output logic [OFF_W-1:0]      upload_offset,
  output logic [TC_W-1:0]       texture_count,
  output logic [SLOT_OUT_W-1:0] slot_index,
  output logic                  last
);

  state_t state, state_next;
  ret_t   ret;

  logic                    has_tex;
  logic [HANDLE_WIDTH-1:0] handle;
  logic [SLOT_W-1:0]       next_slot;
  logic [CACHE_W-1:0]      cached;
  logic [COMMIT_W-1:0]     committed;
  logic [SLOT_W-1:0]       slot;
  logic [SLOT_W-1:0]       scan;
  logic [SLOT_W-1:0]       cmp_idx;

  logic [HANDLE_WIDTH-1:0] slot_mem [TEXTURE_SLOTS];
  logic [HANDLE_WIDTH-1:0] rdata;

  logic hit, more, table_full, batch_full, cache_full;

  logic                  emit;
  logic [KIND_W-1:0]     ev_kind;
  logic [QC_W-1:0]       ev_qc;
  logic [OFF_W-1:0]      ev_off;
  logic [TC_W-1:0]       ev_tc;
  logic [SLOT_OUT_W-1:0] ev_slot;
  logic                  ev_last;

  assign busy       = (state != S_IDLE);
  assign hit        = (rdata == handle);
  assign more       = (scan < next_slot);
  assign table_full = (next_slot >= SLOT_W'(TEXTURE_SLOTS - 1));
  assign batch_full = ((SUM_W'(committed) + SUM_W'(cached)) >= SUM_W'(MAX_QUADS));
  assign cache_full = ((cached + CACHE_W'(1)) >= CACHE_W'(CACHE_QUADS));

  // slot table: one read per cycle at scan, written on insert
  always_ff @(posedge clk) begin
    if (state == S_STORE) begin
      slot_mem[next_slot] <= handle;
    end
    rdata   <= slot_mem[scan];
    cmp_idx <= scan;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (req_type == REQ_FLUSH) state_next = S_END_UP;
          else if (batch_full)       state_next = S_END_UP;
          else                       state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (!has_tex)                          state_next = S_EMIT_SLOT;
        else if (next_slot > SLOT_W'(1))       state_next = S_READ;
        else if (table_full)                   state_next = S_END_UP;
        else                                   state_next = S_STORE;
      end
      S_READ: state_next = S_SEARCH;
      S_SEARCH: begin
        if (hit)             state_next = S_EMIT_SLOT;
        else if (more)       state_next = S_SEARCH;
        else if (table_full) state_next = S_END_UP;
        else                 state_next = S_STORE;
      end
      S_END_UP: state_next = S_END_DRAW;
      S_END_DRAW: begin
        case (ret)
          RET_LOOKUP: state_next = S_LOOKUP;
          RET_STORE:  state_next = S_STORE;
          default:    state_next = S_IDLE;
        endcase
      end
      S_STORE:     state_next = S_EMIT_SLOT;
      S_EMIT_SLOT: state_next = cache_full ? S_CACHE_UP : S_IDLE;
      S_CACHE_UP:  state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    emit    = 1'b0;
    ev_kind = EV_SLOT;
    ev_qc   = '0;
    ev_off  = '0;
    ev_tc   = '0;
    ev_slot = '0;
    ev_last = 1'b0;
    case (state)
      S_END_UP: begin
        emit    = (cached != '0);
        ev_kind = EV_UPLOAD;
        ev_qc   = QC_W'(cached);
        ev_off  = OFF_W'(committed);
      end
      S_END_DRAW: begin
        emit    = (committed != '0);
        ev_kind = EV_DRAW;
        ev_qc   = QC_W'(committed);
        ev_tc   = TC_W'(next_slot);
        ev_last = (ret == RET_IDLE);
      end
      S_EMIT_SLOT: begin
        emit    = 1'b1;
        ev_kind = EV_SLOT;
        ev_slot = SLOT_OUT_W'(slot);
        ev_last = !cache_full;
      end
      S_CACHE_UP: begin
        emit    = 1'b1;
        ev_kind = EV_UPLOAD;
        ev_qc   = QC_W'(cached);
        ev_off  = OFF_W'(committed);
        ev_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ret         <= RET_IDLE;
      next_slot   <= SLOT_W'(1);
      cached      <= '0;
      committed   <= '0;
      event_valid <= 1'b0;
    end else begin
      state       <= state_next;
      event_valid <= emit;
      case (state)
        S_IDLE: begin
          if (start) begin
            has_tex <= has_texture;
            handle  <= texture_id[HANDLE_WIDTH-1:0];
            ret     <= (req_type == REQ_FLUSH) ? RET_IDLE : RET_LOOKUP;
          end
        end
        S_LOOKUP: begin
          scan <= SLOT_W'(1);
          slot <= '0;
          ret  <= RET_STORE;
        end
        S_READ:   scan <= scan + SLOT_W'(1);
        S_SEARCH: begin
          scan <= scan + SLOT_W'(1);
          if (hit) slot <= cmp_idx;
        end
        S_END_UP: begin
          committed <= committed + COMMIT_W'(cached);
          cached    <= '0;
        end
        S_END_DRAW: begin
          committed <= '0;
          next_slot <= SLOT_W'(1);
        end
        S_STORE: begin
          slot      <= next_slot;
          next_slot <= next_slot + SLOT_W'(1);
        end
        S_EMIT_SLOT: cached <= cached + CACHE_W'(1);
        S_CACHE_UP: begin
          committed <= committed + COMMIT_W'(cached);
          cached    <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      event_kind    <= ev_kind;
      quad_count    <= ev_qc;
      upload_offset <= ev_off;
      texture_count <= ev_tc;
      slot_index    <= ev_slot;
      last          <= ev_last;
    end
  end

endmodule

// ===== src/dbtsc_checker.sv =====
`timescale 1ns / 1ps

module dbtsc_checker
  import dbtsc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  req_type,
  input logic                  has_texture,
  input logic [ID_W-1:0]       texture_id,
  input logic                  event_valid,
  input logic [KIND_W-1:0]     event_kind,
  input logic [QC_W-1:0]       quad_count,
  input logic [OFF_W-1:0]      upload_offset,
  input logic [TC_W-1:0]       texture_count,
  input logic [SLOT_OUT_W-1:0] slot_index,
  input logic                  last
);

  // a result only follows a cycle in which a transaction was in flight
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    event_valid |-> $past(busy))
    else $error("result without transaction in flight");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    event_valid |-> (event_kind == EV_UPLOAD || event_kind == EV_DRAW ||
                     event_kind == EV_SLOT))
    else $error("illegal event kind");

  a_draw_nonempty: assert property (@(posedge clk) disable iff (rst)
    (event_valid && event_kind == EV_DRAW) |->
      (quad_count != '0 && texture_count != '0))
    else $error("empty draw issued");

  a_upload_size: assert property (@(posedge clk) disable iff (rst)
    (event_valid && event_kind == EV_UPLOAD) |->
      (quad_count != '0 && quad_count <= QC_W'(CACHE_QUADS)))
    else $error("upload size out of range");

  // the final result of a transaction leaves the block free
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (event_valid && last) |-> !busy)
    else $error("busy after final result");

endmodule

bind draw_batch_texture_slot_cache_core dbtsc_checker u_dbtsc_checker (.*);

// ===== tb/sv/tb_draw_batch_texture_slot_cache_core.sv =====
`timescale 1ns / 1ps

module tb_draw_batch_texture_slot_cache_core;
  import dbtsc_pkg::*;

  localparam logic REQ_DRAW    = ~REQ_FLUSH;
  localparam int   STALL_LIMIT = 4000;
  localparam int   RANDOM_ITEMS = 500;
  localparam int   QUIET_FROM   = 400;  // no idling from here on
  localparam int   TAIL_CYCLES  = 16;
  localparam int   POOL_MAX     = 40;
  localparam int   N_ROWS       = 17;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [QC_W-1:0]       qc;
    logic [OFF_W-1:0]      off;
    logic [TC_W-1:0]       tc;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  last;
  } quad_event_t;

  localparam quad_event_t NO_EVENT = '0;

  typedef struct {
    logic            rq;
    logic            ht;
    logic [ID_W-1:0] id;
    int              reps;
    int              id_step;
    bit              typed;
    int              n_typed;
    quad_event_t     ev;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  req_type = 1'b0;
  logic                  has_texture = 1'b0;
  logic [ID_W-1:0]       texture_id = '0;
  logic                  event_valid;
  logic [KIND_W-1:0]     event_kind;
  logic [QC_W-1:0]       quad_count;
  logic [OFF_W-1:0]      upload_offset;
  logic [TC_W-1:0]       texture_count;
  logic [SLOT_OUT_W-1:0] slot_index;
  logic                  last;

  draw_batch_texture_slot_cache_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .has_texture  (has_texture),
    .texture_id   (texture_id),
    .event_valid  (event_valid),
    .event_kind   (event_kind),
    .quad_count   (quad_count),
    .upload_offset(upload_offset),
    .texture_count(texture_count),
    .slot_index   (slot_index),
    .last         (last)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [HANDLE_WIDTH-1:0] slot_handles [TEXTURE_SLOTS];
  int unsigned free_slot   = 1;
  int unsigned cached_n    = 0;
  int unsigned committed_n = 0;

  quad_event_t step_events [$];
  quad_event_t awaited_events [$];
  int          mismatches = 0;
  int          stall_cycles = 0;
  int          random_items = 0;
  bit          quiet = 1'b0;

  task automatic log_event(input logic [KIND_W-1:0] kind, input int unsigned qc,
                           input int unsigned off, input int unsigned tc,
                           input int unsigned slot);
    quad_event_t ev;
    ev.kind = kind;
    ev.qc   = qc[QC_W-1:0];
    ev.off  = off[OFF_W-1:0];
    ev.tc   = tc[TC_W-1:0];
    ev.slot = slot[SLOT_OUT_W-1:0];
    ev.last = 1'b0;
    step_events.push_back(ev);
  endtask

  task automatic cache_upload();
    if (cached_n != 0) begin
      log_event(EV_UPLOAD, cached_n, committed_n, 0, 0);
      committed_n += cached_n;
      cached_n = 0;
    end
  endtask

  task automatic batch_end();
    cache_upload();
    if (committed_n != 0) begin
      log_event(EV_DRAW, committed_n, 0, free_slot, 0);
      committed_n = 0;
    end
    free_slot = 1;
  endtask

  task automatic slot_lookup(input logic [HANDLE_WIDTH-1:0] handle,
                             output int unsigned slot);
    bit hit;
    hit = 1'b0;
    slot = 0;
    for (int i = 1; i < free_slot; i++) begin
      if (!hit && slot_handles[i] == handle) begin
        hit = 1'b1;
        slot = i;
      end
    end
    if (!hit) begin
      // table one short of full: close the batch before storing
      if (free_slot >= TEXTURE_SLOTS - 1) batch_end();
      slot_handles[free_slot] = handle;
      slot = free_slot;
      free_slot++;
    end
  endtask

  task automatic model_request(input logic rq, input logic ht, input logic [ID_W-1:0] id);
    int unsigned slot;
    quad_event_t tail;
    step_events.delete();
    slot = 0;
    if (rq == REQ_FLUSH) begin
      batch_end();
    end else begin
      if (committed_n + cached_n >= MAX_QUADS) batch_end();
      if (ht) slot_lookup(id[HANDLE_WIDTH-1:0], slot);
      log_event(EV_SLOT, 0, 0, 0, slot);
      cached_n++;
      if (cached_n >= CACHE_QUADS) cache_upload();
    end
    if (step_events.size() != 0) begin
      tail = step_events.pop_back();
      tail.last = 1'b1;
      step_events.push_back(tail);
    end
  endtask

  task automatic maybe_pause();
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 13);
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // drive one transaction, wait for it to be taken, queue what it should produce
  task automatic send_request(input logic rq, input logic ht, input logic [ID_W-1:0] id,
                              input bit typed, input int n_typed, input quad_event_t tev);
    maybe_pause();
    @(negedge clk);
    start       <= 1'b1;
    req_type    <= rq;
    has_texture <= ht;
    texture_id  <= id;
    do @(posedge clk); while (busy);
    model_request(rq, ht, id);
    if (typed) begin
      if (n_typed != 0) awaited_events.push_back(tev);
    end else begin
      foreach (step_events[i]) awaited_events.push_back(step_events[i]);
    end
  endtask

  task automatic send_random(input logic rq, input logic ht, input logic [ID_W-1:0] id);
    send_request(rq, ht, id, 1'b0, 0, NO_EVENT);
    if (step_events.size() != 0) random_items++;
    quiet = (random_items >= QUIET_FROM);
  endtask

  task automatic report(input string what, input quad_event_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected kind %0d qc %0d off %0d tc %0d slot %0d last %0d, got kind %0d qc %0d off %0d tc %0d slot %0d last %0d",
               what, want.kind, want.qc, want.off, want.tc, want.slot, want.last,
               event_kind, quad_count, upload_offset, texture_count, slot_index, last);
  endtask

  always @(posedge clk) begin
    quad_event_t want;
    if (!rst && event_valid) begin
      if (awaited_events.size() == 0) begin
        report("unexpected result", NO_EVENT);
      end else begin
        want = awaited_events.pop_front();
        if (want.kind !== event_kind || want.qc !== quad_count ||
            want.off !== upload_offset || want.tc !== texture_count ||
            want.slot !== slot_index || want.last !== last)
          report("result mismatch", want);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || event_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_draw_batch_texture_slot_cache_core NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    stim_row_t       script [N_ROWS];
    logic [ID_W-1:0] tex_pool [POOL_MAX];
    int              pool_n;
    int              len;
    logic            ht;
    logic [ID_W-1:0] id;

    script = '{
      '{REQ_FLUSH, 1'b0, 32'h0,         1,    0, 1'b1, 0, NO_EVENT},  // nothing pending
      '{REQ_DRAW,  1'b0, 32'h0,         1,    0, 1'b1, 1,
        '{EV_SLOT, 11'd0, 10'd0, 5'd0, 5'd0, 1'b1}},                  // white slot
      '{REQ_DRAW,  1'b1, 32'h0,         1,    0, 1'b1, 1,
        '{EV_SLOT, 11'd0, 10'd0, 5'd0, 5'd1, 1'b1}},
      '{REQ_DRAW,  1'b1, 32'hFFFF_FFFF, 1,    0, 1'b1, 1,
        '{EV_SLOT, 11'd0, 10'd0, 5'd0, 5'd2, 1'b1}},
      '{REQ_DRAW,  1'b1, 32'h0,         1,    0, 1'b1, 1,
        '{EV_SLOT, 11'd0, 10'd0, 5'd0, 5'd1, 1'b1}},                  // hit
      '{REQ_DRAW,  1'b0, 32'hA5A5_A5A5, 1,    0, 1'b1, 1,
        '{EV_SLOT, 11'd0, 10'd0, 5'd0, 5'd0, 1'b1}},                  // handle ignored
      '{REQ_FLUSH, 1'b1, 32'h5A5A_5A5A, 1,    0, 1'b0, 0, NO_EVENT},
      '{REQ_FLUSH, 1'b0, 32'h0,         1,    0, 1'b1, 0, NO_EVENT},
      '{REQ_DRAW,  1'b0, 32'hFFFF_FFFF, 15,   0, 1'b0, 0, NO_EVENT},
      '{REQ_DRAW,  1'b1, 32'h8000_0000, 1,    0, 1'b0, 0, NO_EVENT},  // cache full
      '{REQ_DRAW,  1'b1, 32'd100,       31,   1, 1'b0, 0, NO_EVENT},  // slot table overflow
      '{REQ_DRAW,  1'b1, 32'd100,       1,    0, 1'b0, 0, NO_EVENT},
      '{REQ_FLUSH, 1'b0, 32'h0,         1,    0, 1'b0, 0, NO_EVENT},
      '{REQ_DRAW,  1'b0, 32'h7FFF_FFFF, 1030, 0, 1'b0, 0, NO_EVENT},  // batch full
      '{REQ_FLUSH, 1'b0, 32'h0,         1,    0, 1'b0, 0, NO_EVENT},
      '{REQ_DRAW,  1'b1, 32'd1,         1,    0, 1'b1, 1,
        '{EV_SLOT, 11'd0, 10'd0, 5'd0, 5'd1, 1'b1}},
      '{REQ_FLUSH, 1'b0, 32'h0,         1,    0, 1'b0, 0, NO_EVENT}
    };

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    foreach (script[r])
      for (int k = 0; k < script[r].reps; k++)
        send_request(script[r].rq, script[r].ht, script[r].id + k * script[r].id_step,
                     script[r].typed, script[r].n_typed, script[r].ev);

    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 8) begin
        // plausible batch: handles from a small pool, near-miss handles mixed in
        pool_n = $urandom_range(1, POOL_MAX);
        for (int i = 0; i < pool_n; i++)
          tex_pool[i] = (i != 0 && $urandom_range(0, 3) == 0)
                        ? tex_pool[0] ^ (32'd1 << $urandom_range(0, 31))
                        : $urandom();
        len = $urandom_range(1, 60);
        for (int j = 0; j < len && random_items < RANDOM_ITEMS; j++) begin
          ht = ($urandom_range(0, 4) != 0);
          id = ht ? tex_pool[$urandom_range(0, pool_n - 1)] : $urandom();
          send_random(REQ_DRAW, ht, id);
        end
        if ($urandom_range(0, 9) < 7)
          send_random(REQ_FLUSH, 1'($urandom_range(0, 1)), $urandom());
      end else begin
        repeat ($urandom_range(1, 8))
          send_random(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (awaited_events.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && awaited_events.size() == 0)
      $display("tb_draw_batch_texture_slot_cache_core OK");
    else
      $display("tb_draw_batch_texture_slot_cache_core NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
src/dbtsc_pkg.sv
src/draw_batch_texture_slot_cache_core.sv
src/dbtsc_checker.sv
tb/sv/tb_draw_batch_texture_slot_cache_core.sv
